[hw/rtl/cau_pkg.sv]
// Shared types and codes of the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_EQ  = 3'd4,
    KIND_NE  = 3'd5
  } cau_kind_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic neg;
    logic ovf;
  } cau_lane_t;

endpackage
`default_nettype wire

[hw/rtl/cau_front.sv]
// Front stages: operand register, products, sums, rounding and divider setup.
`timescale 1ns / 1ps
`default_nettype none
module cau_front #(
  parameter int W  = 16,
  parameter int F  = 8,
  parameter int RW = 3 * W + F + 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [2:0]            in_kind,
  input  wire logic signed [W-1:0]   in_a_re,
  input  wire logic signed [W-1:0]   in_a_im,
  input  wire logic signed [W-1:0]   in_b_re,
  input  wire logic signed [W-1:0]   in_b_im,
  output logic                       out_valid,
  output logic [2*W+4:0]             out_side,
  output logic [RW-1:0]              out_rem_re,
  output logic [RW-1:0]              out_rem_im,
  output logic [2*W-1:0]             out_den,
  output cau_pkg::cau_lane_t         out_ctl_re,
  output cau_pkg::cau_lane_t         out_ctl_im
);
  import cau_pkg::*;

  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int NW = 2 * W + F + 1;
  localparam logic signed [SW-1:0] HALF = (SW'(1) << F) >> 1;
  localparam logic signed [SW-1:0] MAX_L = {{(W + 2){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [SW-1:0] MIN_L = {{(W + 2){1'b1}}, {(W - 1){1'b0}}};
  localparam logic signed [W:0] MAX_A = {2'b00, {(W - 1){1'b1}}};
  localparam logic signed [W:0] MIN_A = {2'b11, {(W - 1){1'b0}}};

  // Stage 1: operands.
  logic v1_r;
  cau_kind_t k1_r;
  logic signed [W-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_r  <= cau_kind_t'(in_kind);
      ar1_r <= in_a_re;
      ai1_r <= in_a_im;
      br1_r <= in_b_re;
      bi1_r <= in_b_im;
    end
  end

  // Stage 2: products, add or subtract, equality.
  logic v2_r;
  cau_kind_t k2_r;
  logic signed [PW-1:0] prr_r, pii_r, pri_r, pir_r, pbb_r, pjj_r;
  logic signed [W:0] as_re_r, as_im_r;
  logic eq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2_r  <= k1_r;
      prr_r <= ar1_r * br1_r;
      pii_r <= ai1_r * bi1_r;
      pri_r <= ar1_r * bi1_r;
      pir_r <= ai1_r * br1_r;
      pbb_r <= br1_r * br1_r;
      pjj_r <= bi1_r * bi1_r;
      if (k1_r == KIND_SUB) begin
        as_re_r <= (W + 1)'(ar1_r) - (W + 1)'(br1_r);
        as_im_r <= (W + 1)'(ai1_r) - (W + 1)'(bi1_r);
      end else begin
        as_re_r <= (W + 1)'(ar1_r) + (W + 1)'(br1_r);
        as_im_r <= (W + 1)'(ai1_r) + (W + 1)'(bi1_r);
      end
      eq2_r <= (ar1_r == br1_r) && (ai1_r == bi1_r);
    end
  end

  // Stage 3: sums of products.
  logic v3_r;
  cau_kind_t k3_r;
  logic signed [SW-1:0] m_re_r, m_im_r, d_re_r, d_im_r;
  logic [PW-1:0] den3_r;
  logic signed [W:0] as_re3_r, as_im3_r;
  logic eq3_r;
  logic signed [SW-1:0] den_sum;

  assign den_sum = SW'(pbb_r) + SW'(pjj_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k3_r     <= k2_r;
      m_re_r   <= SW'(prr_r) - SW'(pii_r);
      m_im_r   <= SW'(pri_r) + SW'(pir_r);
      d_re_r   <= SW'(prr_r) + SW'(pii_r);
      d_im_r   <= SW'(pir_r) - SW'(pri_r);
      den3_r   <= den_sum[PW-1:0];
      as_re3_r <= as_re_r;
      as_im3_r <= as_im_r;
      eq3_r    <= eq2_r;
    end
  end

  // Stage 4: rounding, saturation of the direct results, divider setup.
  logic signed [SW-1:0] mr_re, mr_im;
  logic [SW-1:0] mag_re, mag_im;
  logic [RW-1:0] n_re, n_im, den_top;
  logic [W-1:0] r_re, r_im;
  logic r_truth, sat_re, sat_im;
  logic [1:0] r_status;

  assign mr_re   = (m_re_r + HALF) >>> F;
  assign mr_im   = (m_im_r + HALF) >>> F;
  assign mag_re  = d_re_r[SW-1] ? SW'(-d_re_r) : SW'(d_re_r);
  assign mag_im  = d_im_r[SW-1] ? SW'(-d_im_r) : SW'(d_im_r);
  assign n_re    = (RW'(NW'(mag_re)) << F) + RW'(den3_r >> 1);
  assign n_im    = (RW'(NW'(mag_im)) << F) + RW'(den3_r >> 1);
  assign den_top = RW'(den3_r) << W;

  always_comb begin
    r_re    = '0;
    r_im    = '0;
    r_truth = 1'b0;
    sat_re  = 1'b0;
    sat_im  = 1'b0;
    case (k3_r)
      KIND_ADD, KIND_SUB: begin
        if (as_re3_r > MAX_A) begin
          r_re = MAX_A[W-1:0]; sat_re = 1'b1;
        end else if (as_re3_r < MIN_A) begin
          r_re = MIN_A[W-1:0]; sat_re = 1'b1;
        end else begin
          r_re = as_re3_r[W-1:0];
        end
        if (as_im3_r > MAX_A) begin
          r_im = MAX_A[W-1:0]; sat_im = 1'b1;
        end else if (as_im3_r < MIN_A) begin
          r_im = MIN_A[W-1:0]; sat_im = 1'b1;
        end else begin
          r_im = as_im3_r[W-1:0];
        end
      end
      KIND_MUL: begin
        if (mr_re > MAX_L) begin
          r_re = MAX_L[W-1:0]; sat_re = 1'b1;
        end else if (mr_re < MIN_L) begin
          r_re = MIN_L[W-1:0]; sat_re = 1'b1;
        end else begin
          r_re = mr_re[W-1:0];
        end
        if (mr_im > MAX_L) begin
          r_im = MAX_L[W-1:0]; sat_im = 1'b1;
        end else if (mr_im < MIN_L) begin
          r_im = MIN_L[W-1:0]; sat_im = 1'b1;
        end else begin
          r_im = mr_im[W-1:0];
        end
      end
      KIND_EQ: r_truth = eq3_r;
      KIND_NE: r_truth = !eq3_r;
      default: begin
      end
    endcase
    r_status = (sat_re || sat_im) ? ST_SAT : ST_OK;
  end

  logic v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side   <= {r_im, r_re, r_truth, r_status, k3_r == KIND_DIV, den3_r == '0};
      out_rem_re <= n_re;
      out_rem_im <= n_im;
      out_den    <= den3_r;
      out_ctl_re <= '{neg: d_re_r[SW-1], ovf: n_re >= den_top};
      out_ctl_im <= '{neg: d_im_r[SW-1], ovf: n_im >= den_top};
    end
  end

  assign out_valid = v4_r;

endmodule
`default_nettype wire

[hw/rtl/cau_div.sv]
// Pipelined restoring divider, two lanes, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cau_div #(
  parameter int W  = 16,
  parameter int RW = 49,
  parameter int SW = 37
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [SW-1:0]      in_side,
  input  wire logic [RW-1:0]      in_rem_re,
  input  wire logic [RW-1:0]      in_rem_im,
  input  wire logic [2*W-1:0]     in_den,
  input  cau_pkg::cau_lane_t      in_ctl_re,
  input  cau_pkg::cau_lane_t      in_ctl_im,
  output logic                    out_valid,
  output logic [SW-1:0]           out_side,
  output logic [W-1:0]            out_q_re,
  output logic [W-1:0]            out_q_im,
  output cau_pkg::cau_lane_t      out_ctl_re,
  output cau_pkg::cau_lane_t      out_ctl_im
);
  import cau_pkg::*;

  logic              v_r      [1:W];
  logic [SW-1:0]     side_r   [1:W];
  logic [RW-1:0]     rem_re_r [1:W];
  logic [RW-1:0]     rem_im_r [1:W];
  logic [W-1:0]      q_re_r   [1:W];
  logic [W-1:0]      q_im_r   [1:W];
  logic [2*W-1:0]    den_r    [1:W];
  cau_lane_t         ctl_re_r [1:W];
  cau_lane_t         ctl_im_r [1:W];

  for (genvar j = 0; j < W; j++) begin : g_stage
    localparam int K = W - 1 - j;
    logic            v_p;
    logic [SW-1:0]   side_p;
    logic [RW-1:0]   rre_p, rim_p, dsh;
    logic [W-1:0]    qre_p, qim_p;
    logic [2*W-1:0]  den_p;
    cau_lane_t       cre_p, cim_p;
    logic            ge_re, ge_im;
    logic [RW-1:0]   rre_nxt, rim_nxt;
    logic [W-1:0]    qre_nxt, qim_nxt;

    if (j == 0) begin : g_first
      assign v_p    = in_valid;
      assign side_p = in_side;
      assign rre_p  = in_rem_re;
      assign rim_p  = in_rem_im;
      assign qre_p  = '0;
      assign qim_p  = '0;
      assign den_p  = in_den;
      assign cre_p  = in_ctl_re;
      assign cim_p  = in_ctl_im;
    end else begin : g_next
      assign v_p    = v_r[j];
      assign side_p = side_r[j];
      assign rre_p  = rem_re_r[j];
      assign rim_p  = rem_im_r[j];
      assign qre_p  = q_re_r[j];
      assign qim_p  = q_im_r[j];
      assign den_p  = den_r[j];
      assign cre_p  = ctl_re_r[j];
      assign cim_p  = ctl_im_r[j];
    end

    assign dsh     = RW'(den_p) << K;
    assign ge_re   = rre_p >= dsh;
    assign ge_im   = rim_p >= dsh;
    assign rre_nxt = ge_re ? rre_p - dsh : rre_p;
    assign rim_nxt = ge_im ? rim_p - dsh : rim_p;
    assign qre_nxt = qre_p | (W'(ge_re) << K);
    assign qim_nxt = qim_p | (W'(ge_im) << K);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[j+1]   <= side_p;
        rem_re_r[j+1] <= rre_nxt;
        rem_im_r[j+1] <= rim_nxt;
        q_re_r[j+1]   <= qre_nxt;
        q_im_r[j+1]   <= qim_nxt;
        den_r[j+1]    <= den_p;
        ctl_re_r[j+1] <= cre_p;
        ctl_im_r[j+1] <= cim_p;
      end
    end
  end

  assign out_valid  = v_r[W];
  assign out_side   = side_r[W];
  assign out_q_re   = q_re_r[W];
  assign out_q_im   = q_im_r[W];
  assign out_ctl_re = ctl_re_r[W];
  assign out_ctl_im = ctl_im_r[W];

endmodule
`default_nettype wire

[hw/rtl/cau_back.sv]
// Output stage: quotient sign and saturation, result selection, output register.
`timescale 1ns / 1ps
`default_nettype none
module cau_back #(
  parameter int W = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*W+4:0]    in_side,
  input  wire logic [W-1:0]      in_q_re,
  input  wire logic [W-1:0]      in_q_im,
  input  cau_pkg::cau_lane_t     in_ctl_re,
  input  cau_pkg::cau_lane_t     in_ctl_im,
  output logic                   out_valid,
  output logic [W-1:0]           out_re,
  output logic [W-1:0]           out_im,
  output logic                   out_truth,
  output logic [1:0]             out_status
);
  import cau_pkg::*;

  localparam logic [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};

  logic [W-1:0] s_re, s_im, dq_re, dq_im, f_re, f_im;
  logic s_truth, is_div, dz, sat_re, sat_im, f_truth;
  logic [1:0] s_status, f_status;

  assign {s_im, s_re, s_truth, s_status, is_div, dz} = in_side;

  always_comb begin
    sat_re = 1'b1;
    if (in_ctl_re.ovf) begin
      dq_re = in_ctl_re.neg ? MINV : MAXV;
    end else if (!in_ctl_re.neg) begin
      dq_re = in_q_re[W-1] ? MAXV : in_q_re;
      sat_re = in_q_re[W-1];
    end else begin
      dq_re = (in_q_re > MINV) ? MINV : W'(-in_q_re);
      sat_re = in_q_re > MINV;
    end
    sat_im = 1'b1;
    if (in_ctl_im.ovf) begin
      dq_im = in_ctl_im.neg ? MINV : MAXV;
    end else if (!in_ctl_im.neg) begin
      dq_im = in_q_im[W-1] ? MAXV : in_q_im;
      sat_im = in_q_im[W-1];
    end else begin
      dq_im = (in_q_im > MINV) ? MINV : W'(-in_q_im);
      sat_im = in_q_im > MINV;
    end

    if (!is_div) begin
      f_re = s_re; f_im = s_im; f_truth = s_truth; f_status = s_status;
    end else if (dz) begin
      f_re = '0; f_im = '0; f_truth = 1'b0; f_status = ST_DZ;
    end else begin
      f_re = dq_re; f_im = dq_im; f_truth = 1'b0;
      f_status = (sat_re || sat_im) ? ST_SAT : ST_OK;
    end
  end

  logic valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re     <= f_re;
      out_im     <= f_im;
      out_truth  <= f_truth;
      out_status <= f_status;
    end
  end

  assign out_valid = valid_r;

endmodule
`default_nettype wire

[hw/rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit: stream in two complex operands and an operation,
// stream out one complex result with truth flag and status.
//
// The input channel carries the operation code in in_tuser and the four
// signed fixed-point parts in in_tdata. Each request produces exactly one
// result on the output channel: the real and imaginary result parts in
// out_tdata, and the comparison flag and status in out_tuser.
// Every operation takes the same path, so results leave in request order.
// Each request passes through four front stages, one divider stage per
// quotient bit, and the output register.
// One request is accepted in every cycle while the output is taken.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_tready falls; nothing is dropped or repeated.
// Reset clears all valid bits, so the pipeline starts empty.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // a_re, a_im, b_re, b_im
  input  wire logic [((4 * WORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // kind
  input  wire logic [2:0]                             in_tuser,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // res_re, res_im
  output logic [((2 * WORD_BITS + 7) / 8) * 8 - 1:0]  out_tdata,
  // truth, status
  output logic [2:0]                                  out_tuser
);
  import cau_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int RW  = 3 * W + FRAC_BITS + 1;
  localparam int SW  = 2 * W + 5;
  localparam int OTW = ((2 * WORD_BITS + 7) / 8) * 8;

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  logic              f_valid;
  logic [SW-1:0]     f_side;
  logic [RW-1:0]     f_rem_re, f_rem_im;
  logic [2*W-1:0]    f_den;
  cau_lane_t         f_ctl_re, f_ctl_im;

  cau_front #(.W(W), .F(FRAC_BITS), .RW(RW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .in_kind    (in_tuser),
    .in_a_re    (in_tdata[W-1:0]),
    .in_a_im    (in_tdata[2*W-1:W]),
    .in_b_re    (in_tdata[3*W-1:2*W]),
    .in_b_im    (in_tdata[4*W-1:3*W]),
    .out_valid  (f_valid),
    .out_side   (f_side),
    .out_rem_re (f_rem_re),
    .out_rem_im (f_rem_im),
    .out_den    (f_den),
    .out_ctl_re (f_ctl_re),
    .out_ctl_im (f_ctl_im)
  );

  logic              d_valid;
  logic [SW-1:0]     d_side;
  logic [W-1:0]      d_q_re, d_q_im;
  cau_lane_t         d_ctl_re, d_ctl_im;

  cau_div #(.W(W), .RW(RW), .SW(SW)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (f_valid),
    .in_side    (f_side),
    .in_rem_re  (f_rem_re),
    .in_rem_im  (f_rem_im),
    .in_den     (f_den),
    .in_ctl_re  (f_ctl_re),
    .in_ctl_im  (f_ctl_im),
    .out_valid  (d_valid),
    .out_side   (d_side),
    .out_q_re   (d_q_re),
    .out_q_im   (d_q_im),
    .out_ctl_re (d_ctl_re),
    .out_ctl_im (d_ctl_im)
  );

  logic [W-1:0] res_re, res_im;
  logic         res_truth;
  logic [1:0]   res_status;

  cau_back #(.W(W)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (d_valid),
    .in_side    (d_side),
    .in_q_re    (d_q_re),
    .in_q_im    (d_q_im),
    .in_ctl_re  (d_ctl_re),
    .in_ctl_im  (d_ctl_im),
    .out_valid  (out_tvalid),
    .out_re     (res_re),
    .out_im     (res_im),
    .out_truth  (res_truth),
    .out_status (res_status)
  );

  assign out_tdata = OTW'({res_im, res_re});
  assign out_tuser = {res_status, res_truth};

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_status == ST_DZ |-> res_re == '0 && res_im == '0 && !res_truth)
    else $error("Division by zero result is not zero.");

  a_truth_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_truth |-> res_status == ST_OK && res_re == '0 && res_im == '0)
    else $error("Comparison result carries data or status.");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("Input stalled while output is empty.");

endmodule
`default_nettype wire

[dv/complex_arithmetic_unit_test.sv]
// Self-checking testbench for the complex arithmetic unit with a built-in predictor.
`timescale 1ns / 1ps
module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam int LATENCY = 21;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] re;
    logic [15:0] im;
    logic truth;
    logic [1:0] status;
  } cau_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0] out_tuser;

  cau_result_t expected_results[$];
  int error_count = 0;
  int cycle_count = 0;
  int hold_off_cycles = 0;
  bit sink_random = 1'b1;

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [15:0] saturate(longint v, ref bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic longint round_product(longint x);
    return (x + 128) >>> 8;
  endfunction

  function automatic longint round_quotient(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cau_result_t compute_result(logic [2:0] kind, logic [15:0] ar_w,
                                                 logic [15:0] ai_w, logic [15:0] br_w,
                                                 logic [15:0] bi_w);
    cau_result_t r;
    longint ar, ai, br, bi, den;
    bit sat;
    ar = longint'($signed(ar_w));
    ai = longint'($signed(ai_w));
    br = longint'($signed(br_w));
    bi = longint'($signed(bi_w));
    sat = 1'b0;
    r = '0;
    case (kind)
      KIND_ADD: begin
        r.re = saturate(ar + br, sat);
        r.im = saturate(ai + bi, sat);
      end
      KIND_SUB: begin
        r.re = saturate(ar - br, sat);
        r.im = saturate(ai - bi, sat);
      end
      KIND_MUL: begin
        r.re = saturate(round_product(ar * br - ai * bi), sat);
        r.im = saturate(round_product(ar * bi + ai * br), sat);
      end
      KIND_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = ST_DZ;
        end else begin
          r.re = saturate(round_quotient((ar * br + ai * bi) * 256, den), sat);
          r.im = saturate(round_quotient((ai * br - ar * bi) * 256, den), sat);
        end
      end
      KIND_EQ: r.truth = (ar == br && ai == bi);
      KIND_NE: r.truth = !(ar == br && ai == bi);
      default: ;
    endcase
    if (sat) r.status = ST_SAT;
    return r;
  endfunction

  task automatic send_request(logic [2:0] kind, logic [15:0] ar, logic [15:0] ai,
                              logic [15:0] br, logic [15:0] bi, bit with_gap);
    int gap;
    gap = with_gap ? gap_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {bi, br, ai, ar};
    expected_results.push_back(compute_result(kind, ar, ai, br, bi));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] random_part();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 7)) - 16'd3;
      3: return 16'($urandom_range(0, 4095)) - 16'd2048;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 3'($urandom_range(6, 7));
    return 3'($urandom_range(0, 5));
  endfunction

  task automatic test_directed();
    send_request(KIND_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 1'b1);
    send_request(KIND_ADD, 16'h0100, 16'h0200, 16'h0080, 16'hff00, 1'b1);
    send_request(KIND_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1'b1);
    send_request(KIND_SUB, 16'h0300, 16'h0000, 16'h0100, 16'h0100, 1'b1);
    send_request(KIND_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00, 1'b1);
    send_request(KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_request(KIND_MUL, 16'h0001, 16'h0000, 16'h0080, 16'h0000, 1'b1);
    send_request(KIND_MUL, 16'hffff, 16'h0000, 16'h0080, 16'h0000, 1'b1);
    send_request(KIND_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send_request(KIND_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 1'b1);
    send_request(KIND_DIV, 16'h0200, 16'h0000, 16'h0100, 16'h0000, 1'b1);
    send_request(KIND_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000, 1'b1);
    send_request(KIND_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000, 1'b1);
    send_request(KIND_DIV, 16'hff00, 16'h0000, 16'h0300, 16'h0000, 1'b1);
    send_request(KIND_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_request(KIND_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8000, 1'b1);
    send_request(KIND_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8001, 1'b1);
    send_request(KIND_NE, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000, 1'b1);
    send_request(KIND_NE, 16'h7fff, 16'h0000, 16'h7ffe, 16'h0000, 1'b1);
    send_request(3'd6, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b1);
    send_request(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
    drain_results();
  endtask

  task automatic test_random(int count);
    logic [15:0] ar, ai, br, bi;
    logic [2:0] kind;
    repeat (count) begin
      kind = random_kind();
      ar = random_part();
      ai = random_part();
      br = random_part();
      bi = random_part();
      if ((kind == KIND_EQ || kind == KIND_NE) && $urandom_range(0, 1)) begin
        br = ar;
        bi = ai;
      end
      if (kind == KIND_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_request(kind, ar, ai, br, bi, $urandom_range(0, 3) != 0);
    end
    drain_results();
  endtask

  task automatic test_back_pressure();
    sink_random = 1'b0;
    hold_off_cycles = 200;
    repeat (100) begin
      send_request(random_kind(), random_part(), random_part(), random_part(),
                   random_part(), 1'b0);
    end
    drain_results();
    sink_random = 1'b1;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[complex_arithmetic_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else if (!sink_random) begin
      out_tready <= 1'b1;
    end else begin
      gap = gap_length();
      out_tready <= (gap == 0) || ($urandom_range(0, gap) == 0);
    end
  end

  always @(posedge clk) begin
    cau_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result re=%h im=%h", out_tdata[15:0], out_tdata[31:16]);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[15:0] !== want.re) begin
          $error("res_re expected %h actual %h", want.re, out_tdata[15:0]);
          error_count++;
        end
        if (out_tdata[31:16] !== want.im) begin
          $error("res_im expected %h actual %h", want.im, out_tdata[31:16]);
          error_count++;
        end
        if (out_tuser[0] !== want.truth) begin
          $error("truth expected %b actual %b", want.truth, out_tuser[0]);
          error_count++;
        end
        if (out_tuser[2:1] !== want.status) begin
          $error("status expected %d actual %d", want.status, out_tuser[2:1]);
          error_count++;
        end
      end
    end
  end

  initial begin
    int settle;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_pressure();
    test_random(1800);
    settle = 0;
    while (settle < 2 * LATENCY) begin
      @(posedge clk);
      settle++;
    end
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[complex_arithmetic_unit] OK");
    end else begin
      $display("[complex_arithmetic_unit] ERROR");
    end
    $finish;
  end

endmodule
